>>> src/esbm_pkg.sv
`timescale 1ns / 1ps

package esbm_pkg;

  localparam int SENSOR_WIDTH  = 240;
  localparam int SENSOR_HEIGHT = 180;
  localparam int NUM_SLICES    = 3;

  localparam int SLICE_PIXELS = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int TOTAL_PIXELS = SLICE_PIXELS * NUM_SLICES;
  localparam int ADDR_W       = $clog2(TOTAL_PIXELS);
  localparam int COORD_W      = 8;
  localparam int COUNT_W      = 8;
  localparam int SAD_W        = 16;
  localparam int SHIFT_W      = 4;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [1:0]         slice_idx_t;

  typedef enum logic [1:0] {
    OP_EVENT  = 2'd0,
    OP_ROTATE = 2'd1,
    OP_FLOW   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic {
    REG_SEARCH_RANGE = 1'b0,
    REG_BLOCK_LEN    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVT_RD,
    ST_EVT_WR,
    ST_FLOW,
    ST_WAIT
  } state_t;

  // write request into the slice store
  typedef struct packed {
    logic   en;
    addr_t  addr;
    count_t data;
  } wr_req_t;

  function automatic addr_t slice_base(input slice_idx_t idx);
    addr_t base;
    base = addr_t'(SLICE_PIXELS) * addr_t'(idx);
    return base;
  endfunction

  function automatic slice_idx_t slice_inc(input slice_idx_t idx);
    slice_idx_t nxt;
    nxt = (idx == slice_idx_t'(NUM_SLICES - 1)) ? '0 : idx + 2'd1;
    return nxt;
  endfunction

endpackage

>>> src/esbm_store.sv
`timescale 1ns / 1ps

module esbm_store (
  input  logic                clk,
  input  esbm_pkg::wr_req_t   wr,
  input  esbm_pkg::addr_t     raddr_a,
  input  esbm_pkg::addr_t     raddr_b,
  output esbm_pkg::count_t    rdata_a,
  output esbm_pkg::count_t    rdata_b
);

  esbm_pkg::count_t mem [esbm_pkg::TOTAL_PIXELS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> src/event_slice_block_matching_flow_top.sv
`timescale 1ns / 1ps
// event requests with pol set and on the sensor pass through accept, read and write back;
// rotate requests are accepted and then clear every pixel of the new current slice; flow
// requests whose window sits on the sensor read (2s+1)^2 * (2r+1)^2 pixel pairs, one pair per
// cycle from the two store read ports, then wait to give the result; a held result stalls that wait
// rst is synchronous: it restores the registers and then runs a clearing pass of
// all 129600 pixels of the store, during which no request is accepted
module event_slice_block_matching_flow_top (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_data,
  // input requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // x[7:0], y[15:8], pol[16], zero fill
  input  logic [1:0]  s_tuser,   // op[1:0]
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // valid_res[0], flow_dx[4:1], flow_dy[8:5], sad[24:9]
);

  // config registers
  logic [2:0] search_range;
  logic [3:0] block_len;

  // state machine and ring position
  esbm_pkg::state_t     state, state_next;
  esbm_pkg::slice_idx_t current_slice;

  // clearing pass
  esbm_pkg::addr_t clr_addr, clr_end;

  // captured request
  logic [esbm_pkg::COORD_W-1:0] qx, qy;
  logic [2:0]                   qr, qs;
  esbm_pkg::addr_t              ev_addr;
  esbm_pkg::addr_t              ref_base, tag_base;

  // search counters
  logic signed [esbm_pkg::SHIFT_W-1:0] cdx, cdy, ci, cj;

  // read pipeline tags, aligned with store read data
  logic                                p_valid, p_first, p_last, p_final;
  logic signed [esbm_pkg::SHIFT_W-1:0] p_dx, p_dy;

  // accumulation
  logic [esbm_pkg::SAD_W-1:0]          acc, best;
  logic signed [esbm_pkg::SHIFT_W-1:0] best_dx, best_dy;
  logic                                done;
  logic [esbm_pkg::COUNT_W-1:0]        absd;
  logic [esbm_pkg::SAD_W-1:0]          sum_cur;

  // store interface
  esbm_pkg::wr_req_t wr;
  esbm_pkg::addr_t   raddr_a, raddr_b;
  esbm_pkg::count_t  rdata_a, rdata_b;

  esbm_store u_store (
    .clk     (clk),
    .wr      (wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // request decode
  esbm_pkg::op_t                in_op;
  logic [esbm_pkg::COORD_W-1:0] in_x, in_y;
  logic                         in_pol;
  logic                         accept;
  logic [2:0]                   in_r;
  logic [4:0]                   reach;
  logic                         ev_ok, flow_ok;
  logic [15:0]                  ev_row_off;

  assign in_op  = esbm_pkg::op_t'(s_tuser);
  assign in_x   = s_tdata[7:0];
  assign in_y   = s_tdata[15:8];
  assign in_pol = s_tdata[16];
  assign accept = s_tvalid && s_tready;

  // radius rounds down; block size zero behaves like one
  assign in_r  = (block_len == 4'd0) ? 3'd0 : 3'((block_len - 4'd1) >> 1);
  assign reach = 5'(in_r) + 5'(search_range);

  assign ev_ok = in_pol && (10'(in_x) < 10'(esbm_pkg::SENSOR_WIDTH))
                        && (10'(in_y) < 10'(esbm_pkg::SENSOR_HEIGHT));

  // whole search window must sit on the sensor
  assign flow_ok = (in_x >= 8'(reach)) && (in_y >= 8'(reach))
                && (10'(in_x) + 10'(reach) < 10'(esbm_pkg::SENSOR_WIDTH))
                && (10'(in_y) + 10'(reach) < 10'(esbm_pkg::SENSOR_HEIGHT));

  assign ev_row_off = 16'(in_y) * 16'(esbm_pkg::SENSOR_WIDTH);

  // search counter end conditions
  logic signed [esbm_pkg::SHIFT_W-1:0] r_pos, s_pos;
  logic j_end, i_end, dy_end, dx_end;

  assign r_pos  = $signed({1'b0, qr});
  assign s_pos  = $signed({1'b0, qs});
  assign j_end  = (cj == r_pos);
  assign i_end  = (ci == r_pos);
  assign dy_end = (cdy == s_pos);
  assign dx_end = (cdx == s_pos);

  // pixel addresses of the current pair
  logic signed [9:0] ref_row, ref_col, tag_row, tag_col;
  logic [15:0]       ref_row_off, tag_row_off;
  esbm_pkg::addr_t   ref_addr, tag_addr;

  assign ref_row = $signed({2'b00, qy}) + 10'(cj);
  assign ref_col = $signed({2'b00, qx}) + 10'(ci);
  assign tag_row = ref_row + 10'(cdy);
  assign tag_col = ref_col + 10'(cdx);

  assign ref_row_off = 16'(ref_row[7:0]) * 16'(esbm_pkg::SENSOR_WIDTH);
  assign tag_row_off = 16'(tag_row[7:0]) * 16'(esbm_pkg::SENSOR_WIDTH);
  assign ref_addr = ref_base + esbm_pkg::addr_t'(ref_row_off)
                  + esbm_pkg::addr_t'(ref_col[7:0]);
  assign tag_addr = tag_base + esbm_pkg::addr_t'(tag_row_off)
                  + esbm_pkg::addr_t'(tag_col[7:0]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      esbm_pkg::ST_CLEAR: begin
        if (clr_addr == clr_end) state_next = esbm_pkg::ST_IDLE;
      end
      esbm_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op)
            esbm_pkg::OP_EVENT:  state_next = ev_ok ? esbm_pkg::ST_EVT_RD : esbm_pkg::ST_IDLE;
            esbm_pkg::OP_ROTATE: state_next = esbm_pkg::ST_CLEAR;
            esbm_pkg::OP_FLOW:   state_next = flow_ok ? esbm_pkg::ST_FLOW : esbm_pkg::ST_IDLE;
            default:             state_next = esbm_pkg::ST_IDLE;
          endcase
        end
      end
      esbm_pkg::ST_EVT_RD: state_next = esbm_pkg::ST_EVT_WR;
      esbm_pkg::ST_EVT_WR: state_next = esbm_pkg::ST_IDLE;
      esbm_pkg::ST_FLOW: begin
        if (j_end && i_end && dy_end && dx_end) state_next = esbm_pkg::ST_WAIT;
      end
      esbm_pkg::ST_WAIT: begin
        if (done && (!m_tvalid || m_tready)) state_next = esbm_pkg::ST_IDLE;
      end
      default: state_next = esbm_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    wr       = '0;
    raddr_a  = ev_addr;
    raddr_b  = tag_addr;
    unique case (state)
      esbm_pkg::ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_addr;
      end
      esbm_pkg::ST_IDLE:   s_tready = 1'b1;
      esbm_pkg::ST_EVT_RD: raddr_a = ev_addr;
      esbm_pkg::ST_EVT_WR: begin
        // counts wrap at 8 bits
        wr.en   = 1'b1;
        wr.addr = ev_addr;
        wr.data = rdata_a + 8'd1;
      end
      esbm_pkg::ST_FLOW:   raddr_a = ref_addr;
      esbm_pkg::ST_WAIT:   ;
      default:             ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= esbm_pkg::ST_CLEAR;
      current_slice <= '0;
      search_range  <= 3'd3;
      block_len     <= 4'd5;
      clr_addr      <= '0;
      clr_end       <= esbm_pkg::addr_t'(esbm_pkg::TOTAL_PIXELS - 1);
      p_valid       <= 1'b0;
      done          <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (esbm_pkg::reg_idx_t'(cfg_addr))
          esbm_pkg::REG_SEARCH_RANGE: search_range <= cfg_data[2:0];
          esbm_pkg::REG_BLOCK_LEN:    block_len    <= cfg_data;
          default:                    ;
        endcase
      end

      if (state == esbm_pkg::ST_CLEAR) clr_addr <= clr_addr + esbm_pkg::addr_t'(1);

      // rotate: advance ring and clear the new current slice
      if (accept && in_op == esbm_pkg::OP_ROTATE) begin
        current_slice <= esbm_pkg::slice_inc(current_slice);
        clr_addr      <= esbm_pkg::slice_base(esbm_pkg::slice_inc(current_slice));
        clr_end       <= esbm_pkg::slice_base(esbm_pkg::slice_inc(current_slice))
                       + esbm_pkg::addr_t'(esbm_pkg::SLICE_PIXELS - 1);
      end

      p_valid <= (state == esbm_pkg::ST_FLOW);

      if (accept) done <= 1'b0;
      else if (p_valid && p_final) done <= 1'b1;

      if (state == esbm_pkg::ST_WAIT && done && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      qx       <= in_x;
      qy       <= in_y;
      qr       <= in_r;
      qs       <= search_range;
      ev_addr  <= esbm_pkg::slice_base(current_slice) + esbm_pkg::addr_t'(ev_row_off)
                + esbm_pkg::addr_t'(in_x);
      // t-1 is two steps ahead in the ring, t-2 one step
      ref_base <= esbm_pkg::slice_base(esbm_pkg::slice_inc(esbm_pkg::slice_inc(current_slice)));
      tag_base <= esbm_pkg::slice_base(esbm_pkg::slice_inc(current_slice));
      cdx      <= -$signed({1'b0, search_range});
      cdy      <= -$signed({1'b0, search_range});
      ci       <= -$signed({1'b0, in_r});
      cj       <= -$signed({1'b0, in_r});
      best     <= '1;
    end else if (state == esbm_pkg::ST_FLOW) begin
      // dx outer, dy inner, then block columns and rows
      if (!j_end) begin
        cj <= cj + 4'sd1;
      end else begin
        cj <= -r_pos;
        if (!i_end) begin
          ci <= ci + 4'sd1;
        end else begin
          ci <= -r_pos;
          if (!dy_end) begin
            cdy <= cdy + 4'sd1;
          end else begin
            cdy <= -s_pos;
            cdx <= cdx + 4'sd1;
          end
        end
      end
    end

    p_first <= (ci == -r_pos) && (cj == -r_pos);
    p_last  <= i_end && j_end;
    p_final <= i_end && j_end && dy_end && dx_end;
    p_dx    <= cdx;
    p_dy    <= cdy;

    if (state == esbm_pkg::ST_WAIT && done && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'd0, best, 4'(best_dy), 4'(best_dx), 1'b1};
    end

    if (p_valid) begin
      acc <= sum_cur;
      // first strict minimum wins
      if (p_last && sum_cur < best) begin
        best    <= sum_cur;
        best_dx <= -p_dx;
        best_dy <= -p_dy;
      end
    end
  end

  // absolute difference and running block sum
  assign absd    = (rdata_a > rdata_b) ? (rdata_a - rdata_b) : (rdata_b - rdata_a);
  assign sum_cur = (p_first ? '0 : acc) + esbm_pkg::SAD_W'(absd);

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import esbm_pkg::*;

  // expected flow result for one flow request
  typedef struct {
    logic [3:0]  dx;
    logic [3:0]  dy;
    logic [15:0] sad;
  } flow_res_t;

  // shadow of the slice store plus the flow search, checks results in order
  class flow_scoreboard;
    byte unsigned counts[NUM_SLICES][SENSOR_HEIGHT][SENSOR_WIDTH];
    int unsigned  cur_slice;
    int unsigned  search_dist;
    int unsigned  blk_size;
    flow_res_t    pending_flows[$];
    int unsigned  errors;

    function void clear_all();
      foreach (counts[s, r, c]) counts[s][r][c] = 0;
      cur_slice   = 0;
      search_dist = 3;
      blk_size    = 5;
    endfunction

    function void write_reg(reg_idx_t idx, logic [3:0] val);
      if (idx == REG_SEARCH_RANGE) search_dist = 32'(val[2:0]);
      else blk_size = 32'(val);
    endfunction

    function int unsigned block_sad(int unsigned rs, int unsigned ts, int x, int y,
                                    int dx, int dy, int r);
      int unsigned sum;
      int a;
      int b;
      sum = 0;
      for (int i = -r; i <= r; i++)
        for (int j = -r; j <= r; j++) begin
          a = int'(counts[rs][y + j][x + i]);
          b = int'(counts[ts][y + dy + j][x + dx + i]);
          sum += (a > b) ? a - b : b - a;
        end
      return sum;
    endfunction

    function void note_request(op_t op, int x, int y, bit pol);
      int r;
      int s;
      int reach;
      int unsigned best;
      int unsigned sum;
      int bdx;
      int bdy;
      flow_res_t res;
      case (op)
        OP_EVENT: begin
          if (pol && x < SENSOR_WIDTH && y < SENSOR_HEIGHT)
            counts[cur_slice][y][x] = counts[cur_slice][y][x] + 8'd1;
        end
        OP_ROTATE: begin
          cur_slice = (cur_slice == 2) ? 0 : cur_slice + 1;
          for (int r2 = 0; r2 < SENSOR_HEIGHT; r2++)
            for (int c2 = 0; c2 < SENSOR_WIDTH; c2++) counts[cur_slice][r2][c2] = 0;
        end
        OP_FLOW: begin
          s = search_dist;
          r = (blk_size == 0) ? 0 : (blk_size - 1) / 2;
          reach = r + s;
          if (x - reach >= 0 && x + reach < SENSOR_WIDTH &&
              y - reach >= 0 && y + reach < SENSOR_HEIGHT) begin
            best = 32'hFFFF_FFFF;
            bdx = 0;
            bdy = 0;
            // dx outer, dy inner, first strict minimum wins
            for (int dx = -s; dx <= s; dx++)
              for (int dy = -s; dy <= s; dy++) begin
                sum = block_sad((cur_slice + 2) % 3, (cur_slice + 1) % 3, x, y, dx, dy, r);
                if (sum < best) begin
                  best = sum;
                  bdx = -dx;
                  bdy = -dy;
                end
              end
            res.dx  = 4'(bdx);
            res.dy  = 4'(bdy);
            res.sad = (best > 32'hFFFF) ? 16'hFFFF : 16'(best);
            pending_flows.push_back(res);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] d);
      flow_res_t exp_res;
      if (pending_flows.size() == 0) begin
        $display("%0t: unexpected flow result %h", $time, d);
        errors++;
        return;
      end
      exp_res = pending_flows.pop_front();
      if (d[0] !== 1'b1) begin
        $display("%0t: valid_res expected 1 actual %b", $time, d[0]);
        errors++;
      end
      if (d[4:1] !== exp_res.dx) begin
        $display("%0t: flow_dx expected %0d actual %0d", $time,
                 $signed(exp_res.dx), $signed(d[4:1]));
        errors++;
      end
      if (d[8:5] !== exp_res.dy) begin
        $display("%0t: flow_dy expected %0d actual %0d", $time,
                 $signed(exp_res.dy), $signed(d[8:5]));
        errors++;
      end
      if (d[24:9] !== exp_res.sad) begin
        $display("%0t: sad expected %0d actual %0d", $time, exp_res.sad, d[24:9]);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 400000;
  // a rotate keeps the block busy for a full slice clear with no result
  localparam int ROTATE_SETTLE  = SLICE_PIXELS + 100;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_addr;
  logic [3:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  flow_scoreboard flow_sb;
  bit             idle_on;
  op_t            last_op;
  int             quiet_cycles;

  event_slice_block_matching_flow_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // sample handshakes at the rising edge, feed the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) flow_sb.write_reg(reg_idx_t'(cfg_addr), cfg_data);
      if (s_tvalid && s_tready)
        flow_sb.note_request(op_t'(s_tuser), int'(s_tdata[7:0]), int'(s_tdata[15:8]),
                             s_tdata[16]);
      if (m_tvalid && m_tready) flow_sb.check_result(m_tdata);
    end
  end

  // watchdog: cycles with no accepted request, result or register write
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stall before each result
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = idle_on ? $urandom_range(0, 17) : 0;
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one request; called right after a falling edge
  task automatic send_req(op_t op, int x, int y, bit pol);
    int n;
    n = idle_on ? $urandom_range(0, 17) : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, pol, 8'(y), 8'(x)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_op = op;
    @(negedge clk);
  endtask

  // hold off until every flow result is back and the block has gone idle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (flow_sb.pending_flows.size() != 0) @(posedge clk);
    repeat ((last_op == OP_ROTATE) ? ROTATE_SETTLE : 60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_search(int unsigned s, int unsigned b);
    drain();
    cfg_we   <= 1'b1;
    cfg_addr <= REG_SEARCH_RANGE;
    cfg_data <= 4'(s);
    @(negedge clk);
    cfg_addr <= REG_BLOCK_LEN;
    cfg_data <= 4'(b);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // random traffic: pattern in one slice, shifted copy in the next, then flow queries
  task automatic motion_episode(int burst);
    int cx;
    int cy;
    int mx;
    int my;
    int px[$];
    int py[$];
    cx = $urandom_range(20, 219);
    cy = $urandom_range(20, 159);
    mx = $urandom_range(0, 4) - 2;
    my = $urandom_range(0, 4) - 2;
    for (int k = 0; k < 12; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        px.push_back(cx + $urandom_range(0, 6) - 3);
        py.push_back(cy + $urandom_range(0, 6) - 3);
        send_req(OP_EVENT, px[$], py[$], 1'b1);
      end else if ($urandom_range(0, 1)) begin
        send_req(OP_EVENT, $urandom_range(0, 255), $urandom_range(0, 255),
                 1'($urandom_range(0, 1)));
      end else begin
        send_req(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                 1'($urandom_range(0, 1)));
      end
    end
    // hammer the center pixel so its count wraps
    for (int k = 0; k < burst; k++) send_req(OP_EVENT, cx, cy, 1'b1);
    send_req(OP_ROTATE, $urandom_range(0, 255), $urandom_range(0, 255),
             1'($urandom_range(0, 1)));
    foreach (px[i]) begin
      send_req(OP_EVENT, px[i] + mx, py[i] + my, 1'b1);
      if ($urandom_range(0, 9) == 0)
        send_req(OP_EVENT, $urandom_range(0, 255), $urandom_range(0, 255),
                 1'($urandom_range(0, 1)));
    end
    send_req(OP_ROTATE, cx, cy, 1'b0);
    for (int k = 0; k < 12; k++) begin
      if ($urandom_range(0, 99) < 80)
        send_req(OP_FLOW, cx + $urandom_range(0, 4) - 2, cy + $urandom_range(0, 4) - 2,
                 1'($urandom_range(0, 1)));
      else
        send_req(OP_FLOW, $urandom_range(0, 255), $urandom_range(0, 255),
                 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    flow_sb = new();
    flow_sb.clear_all();
    flow_sb.errors = 0;
    idle_on  = 1'b1;
    last_op  = OP_EVENT;
    quiet_cycles = 0;
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_addr = REG_SEARCH_RANGE;
    cfg_data = 4'd0;
    s_tvalid = 1'b0;
    s_tdata  = 24'd0;
    s_tuser  = OP_EVENT;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: corners, ignored events, unused opcode, window edges
    send_req(OP_EVENT, 0, 0, 1'b1);
    send_req(OP_EVENT, 239, 179, 1'b1);
    send_req(OP_EVENT, 120, 90, 1'b0);
    send_req(OP_EVENT, 255, 255, 1'b1);
    send_req(OP_EVENT, 240, 0, 1'b1);
    send_req(OP_EVENT, 0, 180, 1'b1);
    send_req(OP_NONE, 120, 90, 1'b1);
    send_req(OP_FLOW, 0, 0, 1'b1);
    send_req(OP_FLOW, 120, 90, 1'b0);
    send_req(OP_ROTATE, 0, 0, 1'b0);
    send_req(OP_EVENT, 1, 1, 1'b1);
    send_req(OP_FLOW, 8, 8, 1'b0);
    send_req(OP_FLOW, 7, 8, 1'b0);
    send_req(OP_FLOW, 231, 171, 1'b0);
    send_req(OP_FLOW, 232, 171, 1'b0);
    // zero block size behaves as a single pixel, no search
    set_search(0, 0);
    send_req(OP_FLOW, 0, 0, 1'b1);
    send_req(OP_FLOW, 239, 179, 1'b1);
    // even block size rounds the radius down
    set_search(2, 4);
    send_req(OP_FLOW, 3, 3, 1'b0);
    send_req(OP_FLOW, 2, 3, 1'b0);
    // widest window once
    set_search(7, 15);
    send_req(OP_FLOW, 14, 14, 1'b1);
    send_req(OP_FLOW, 13, 14, 1'b1);
    send_req(OP_FLOW, 225, 166, 1'b1);

    set_search(3, 5);
    motion_episode(0);
    idle_on = 1'b0;
    set_search(0, 1);
    motion_episode(258);
    idle_on = 1'b1;
    // sender waits for every outstanding flow before carrying on
    drain();
    set_search(7, 3);
    motion_episode(0);
    set_search(1, 14);
    motion_episode(0);
    set_search(2, 0);
    motion_episode(0);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (flow_sb.pending_flows.size() != 0) @(posedge clk);
    repeat ((last_op == OP_ROTATE) ? ROTATE_SETTLE : 200) @(posedge clk);
    if (flow_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
src/esbm_pkg.sv
src/esbm_store.sv
src/event_slice_block_matching_flow_top.sv
dv/tb_top.sv
